// ===== hdl/ipv6_routing_header_processor_assert.svh =====
// assertion macros shared by the routing header processor
`ifndef IPV6_ROUTING_HEADER_PROCESSOR_ASSERT_SVH
`define IPV6_ROUTING_HEADER_PROCESSOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IPRH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IPRH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/iprh_pkg.sv =====
// ----------------------------------------------------------------------------
// iprh_pkg
// shared constants, codes and helpers of the ipv6 routing header processor
// ----------------------------------------------------------------------------
package iprh_pkg;

  localparam int MAX_PKT_BYTES_DEF = 2048;
  localparam logic [6:0] MAX_ADDR_RST = 7'd23;

  localparam int OFS_W = 11;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 168;
  localparam int OUT_USER_W = 2;

  typedef logic [2:0] phase_t;
  typedef logic [1:0] verdict_t;

  localparam phase_t PH_FIXED = 3'd0;
  localparam phase_t PH_EXT8 = 3'd1;
  localparam phase_t PH_ESP = 3'd2;
  localparam phase_t PH_FRAG = 3'd3;
  localparam phase_t PH_ROUT = 3'd4;
  localparam phase_t PH_CAPT = 3'd5;
  localparam phase_t PH_SKIP = 3'd6;
  localparam phase_t PH_END = 3'd7;

  localparam verdict_t V_PLAIN = 2'd0;
  localparam verdict_t V_REWRITE = 2'd1;
  localparam verdict_t V_DROP = 2'd2;
  localparam verdict_t V_TRUNC = 2'd3;

  localparam logic [7:0] NH_HOPOPT = 8'd0;
  localparam logic [7:0] NH_ROUTING = 8'd43;
  localparam logic [7:0] NH_FRAG = 8'd44;
  localparam logic [7:0] NH_ESP = 8'd50;
  localparam logic [7:0] NH_DSTOPT = 8'd60;
  localparam logic [7:0] RT_TYPE0 = 8'd0;

  // parse phase for a header kind, PH_END when the walk stops
  function automatic phase_t iprh_enter_phase(input logic [7:0] kind);
    phase_t ph;
    case (kind)
      NH_HOPOPT, NH_DSTOPT: ph = PH_EXT8;
      NH_ESP: ph = PH_ESP;
      NH_FRAG: ph = PH_FRAG;
      NH_ROUTING: ph = PH_ROUT;
      default: ph = PH_END;
    endcase
    return ph;
  endfunction

endpackage

// ===== hdl/ipv6_routing_header_processor.sv =====
// ----------------------------------------------------------------------------
// ipv6_routing_header_processor
// walks the ipv6 extension header chain and reports type 0 routing rewrites
// ----------------------------------------------------------------------------
// One packet byte is taken per cycle, starting at the fixed header, and each
// byte passes through the header walker in the cycle it is accepted. At most
// one result per packet leaves from a single output register in the cycle after
// the byte that settles the verdict (or after the final byte if none did).
// in_tready drops only while a result sits in that register and out_tready
// is low; otherwise a byte can be accepted every cycle.
module ipv6_routing_header_processor #(
  parameter int MAX_PKT_BYTES = iprh_pkg::MAX_PKT_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [6:0]                        cfg_wr_data,   // max_addresses
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [iprh_pkg::IN_DATA_W-1:0]    in_tdata,      // data_byte
  input  logic                              in_tlast,      // last_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // hop_limit_out, segments_left_out, segments_left_offset, swap_offset,
  // new_dst_high, new_dst_low, zero fill
  output logic [iprh_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [iprh_pkg::OUT_USER_W-1:0]   out_tuser      // verdict
);

  import iprh_pkg::*;

  localparam int PW = $clog2(MAX_PKT_BYTES + 1);
  localparam int JW = $clog2(MAX_PKT_BYTES + 2049) + 1;
  localparam logic [JW-1:0] MAX_J = JW'(MAX_PKT_BYTES);
  localparam logic [PW-1:0] MAX_P = PW'(MAX_PKT_BYTES);

  logic [6:0]    max_addr_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    kind_r, kind_nxt;
  logic [PW-1:0] hs_r, hs_nxt;
  logic [7:0]    hop_r, hop_nxt;
  logic [7:0]    rlen_r, rlen_nxt;
  logic [7:0]    seg_r, seg_nxt;
  logic [PW-1:0] swap_r, swap_nxt;
  phase_t        phase_r, phase_nxt;
  logic          decided_r, decided_nxt;
  logic [127:0]  addr_r, addr_nxt;

  logic          out_valid_r;
  verdict_t      out_user_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic          in_acc;
  logic          res_vld;
  verdict_t      res_code;
  logic [OUT_DATA_W-1:0] res_data;
  logic [JW-1:0] off_w;
  logic [JW-1:0] jump_w;
  logic [JW-1:0] swap_w;
  logic [6:0]    count;
  logic [7:0]    b;
  phase_t        enter_ph;
  logic          go_jump;
  logic          go_enter;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc = in_tvalid && in_tready;
  assign b = in_tdata;

  always_comb begin
    pos_nxt = pos_r;
    kind_nxt = kind_r;
    hs_nxt = hs_r;
    hop_nxt = hop_r;
    rlen_nxt = rlen_r;
    seg_nxt = seg_r;
    swap_nxt = swap_r;
    phase_nxt = phase_r;
    decided_nxt = decided_r;
    addr_nxt = addr_r;
    res_vld = 1'b0;
    res_code = V_PLAIN;
    res_data = '0;
    off_w = JW'(pos_r) - JW'(hs_r);
    jump_w = '0;
    count = rlen_r[7:1];
    swap_w = '0;
    go_jump = 1'b0;
    go_enter = 1'b0;
    enter_ph = PH_END;

    if (in_acc) begin
      if (pos_r < MAX_P) begin
        pos_nxt = pos_r + PW'(1);
        if (!decided_r) begin
          case (phase_r)
            PH_FIXED: begin
              if (pos_r == PW'(6)) kind_nxt = b;
              if (pos_r == PW'(7)) begin
                hop_nxt = b;
                if (b == 8'd0) begin
                  res_vld = 1'b1;
                  res_code = V_DROP;
                end
              end
              if (pos_r == PW'(39)) begin
                hs_nxt = PW'(40);
                go_enter = 1'b1;
              end
            end
            PH_SKIP: begin
              if (JW'(pos_r) + JW'(1) == JW'(hs_r)) go_enter = 1'b1;
            end
            PH_EXT8: begin
              if (off_w == JW'(0)) kind_nxt = b;
              if (off_w == JW'(1)) begin
                jump_w = JW'(hs_r) + ((JW'(b) + JW'(1)) << 3);
                go_jump = 1'b1;
              end
            end
            PH_ESP: begin
              if (off_w == JW'(0)) kind_nxt = b;
              if (off_w == JW'(1)) begin
                jump_w = JW'(hs_r) + ((JW'(b) + JW'(2)) << 2);
                go_jump = 1'b1;
              end
            end
            PH_FRAG: begin
              if (off_w == JW'(0)) begin
                kind_nxt = b;
                jump_w = JW'(hs_r) + JW'(8);
                go_jump = 1'b1;
              end
            end
            PH_ROUT: begin
              if (off_w == JW'(1)) rlen_nxt = b;
              if (off_w == JW'(2)) kind_nxt = b;
              if (off_w == JW'(3)) begin
                res_vld = 1'b1;
                if (kind_r != RT_TYPE0) begin
                  res_code = V_PLAIN;
                end else if (rlen_r[0]) begin
                  res_code = V_DROP;
                end else if (count > max_addr_r) begin
                  res_code = V_DROP;
                end else if (b == 8'd0) begin
                  res_code = V_PLAIN;
                end else if (b > {1'b0, count}) begin
                  res_code = V_DROP;
                end else begin
                  seg_nxt = b;
                  swap_w = JW'(hs_r) + JW'(8) + (JW'(count - b[6:0]) << 4);
                  swap_nxt = PW'(swap_w);
                  if (swap_w + JW'(16) > MAX_J) begin
                    res_code = V_TRUNC;
                  end else begin
                    res_vld = 1'b0;
                    addr_nxt = '0;
                    phase_nxt = PH_CAPT;
                  end
                end
              end
            end
            PH_CAPT: begin
              if (pos_r >= swap_r) begin
                addr_nxt = {addr_r[119:0], b};
                if (JW'(pos_r) == JW'(swap_r) + JW'(15)) begin
                  res_vld = 1'b1;
                  res_code = V_REWRITE;
                end
              end
            end
            default: begin
            end
          endcase

          if (go_jump) begin
            hs_nxt = PW'(jump_w);
            if (jump_w > MAX_J) begin
              res_vld = 1'b1;
              res_code = V_TRUNC;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end

          if (go_enter) begin
            enter_ph = iprh_enter_phase(kind_nxt);
            if (enter_ph == PH_END) begin
              res_vld = 1'b1;
              res_code = V_PLAIN;
            end else begin
              phase_nxt = enter_ph;
            end
          end
        end
      end

      if (res_vld) begin
        decided_nxt = 1'b1;
      end else if (in_tlast && !decided_r) begin
        res_vld = 1'b1;
        res_code = V_TRUNC;
      end

      res_data[7:0] = hop_nxt;
      if (res_code == V_REWRITE) begin
        res_data[7:0] = hop_nxt - 8'd1;
        res_data[15:8] = seg_nxt - 8'd1;
        res_data[26:16] = OFS_W'(JW'(hs_nxt) + JW'(3));
        res_data[37:27] = OFS_W'(JW'(swap_nxt));
        res_data[101:38] = addr_nxt[127:64];
        res_data[165:102] = addr_nxt[63:0];
      end

      if (in_tlast) begin
        pos_nxt = '0;
        kind_nxt = '0;
        hs_nxt = '0;
        hop_nxt = '0;
        rlen_nxt = '0;
        seg_nxt = '0;
        swap_nxt = '0;
        phase_nxt = PH_FIXED;
        decided_nxt = 1'b0;
        addr_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_addr_r <= MAX_ADDR_RST;
      pos_r <= '0;
      kind_r <= '0;
      hs_r <= '0;
      hop_r <= '0;
      rlen_r <= '0;
      seg_r <= '0;
      swap_r <= '0;
      phase_r <= PH_FIXED;
      decided_r <= 1'b0;
      addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) max_addr_r <= cfg_wr_data;
      pos_r <= pos_nxt;
      kind_r <= kind_nxt;
      hs_r <= hs_nxt;
      hop_r <= hop_nxt;
      rlen_r <= rlen_nxt;
      seg_r <= seg_nxt;
      swap_r <= swap_nxt;
      phase_r <= phase_nxt;
      decided_r <= decided_nxt;
      addr_r <= addr_nxt;
      if (in_acc && res_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_vld) begin
      out_user_r <= res_code;
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_user_r;
  assign out_tdata = out_data_r;

`include "ipv6_routing_header_processor_assert.svh"

  `IPRH_ASSERT_NOW(a_no_second_result, in_acc && decided_r, !res_vld || !decided_nxt || in_tlast, "result after packet already decided")
  `IPRH_ASSERT_NOW(a_rewrite_from_capture, in_acc && res_vld && res_code == V_REWRITE, phase_r == PH_CAPT, "rewrite verdict outside address capture")
  `IPRH_ASSERT_NEXT(a_clear_after_last, in_acc && in_tlast, pos_r == '0 && !decided_r && phase_r == PH_FIXED, "packet state not cleared after last byte")
  `IPRH_ASSERT_NOW(a_pos_in_window, 1'b1, pos_r <= MAX_P, "byte position beyond window")

endmodule
